// ----- hw/rtl/cops_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cops_pkg
// shared types, constants and arithmetic helpers of the orbit position step
// ---------------------------------------------------------------------------
package cops_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ITER_W        = $clog2(CORDIC_STAGES);

    localparam int ANG_W  = 26;
    localparam int Z_W    = 27;
    localparam int XY_W   = 33;
    localparam int CFG_W  = 25;
    localparam int CIDX_W = 3;

    localparam logic [ANG_W-1:0] FULL_TURN          = 26'd23592960;
    localparam logic [ANG_W-1:0] HALF_TURN          = 26'd11796480;
    localparam logic [ANG_W-1:0] QUARTER_TURN       = 26'd5898240;
    localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 26'd17694720;

    localparam logic signed [XY_W-1:0] CORDIC_START = 33'sd652032874;

    typedef enum logic [CIDX_W-1:0] {
        CFG_RADIUS     = 3'd0,
        CFG_SPEED      = 3'd1,
        CFG_TILT       = 3'd2,
        CFG_HAS_PARENT = 3'd3,
        CFG_PAUSED     = 3'd4
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADV,
        S_LOAD,
        S_ROT,
        S_PROD1,
        S_PROD2,
        S_PROD3,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        [19:0] delta_time;
        logic signed [31:0] parent_x;
        logic signed [31:0] parent_y;
        logic signed [31:0] parent_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [31:0]      pos_z;
        logic        [ANG_W-1:0] angle_out;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic step_mul;
        logic step_adv;
        logic cordic_load;
        logic cordic_iter;
        logic prod1;
        logic prod2;
        logic prod3;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic iter_last;
    } t_dp_stat;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_vec;

    typedef struct packed {
        logic signed [Z_W-1:0] z;
        logic                  flip;
    } t_seed;

    function automatic logic signed [Z_W-1:0] arctan(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 27'sd2949120;
            1:       r = 27'sd1740967;
            2:       r = 27'sd919879;
            3:       r = 27'sd466945;
            4:       r = 27'sd234379;
            5:       r = 27'sd117304;
            6:       r = 27'sd58666;
            7:       r = 27'sd29335;
            8:       r = 27'sd14668;
            9:       r = 27'sd7334;
            10:      r = 27'sd3667;
            11:      r = 27'sd1833;
            12:      r = 27'sd917;
            13:      r = 27'sd458;
            14:      r = 27'sd229;
            15:      r = 27'sd115;
            16:      r = 27'sd57;
            17:      r = 27'sd29;
            18:      r = 27'sd14;
            19:      r = 27'sd7;
            20:      r = 27'sd4;
            21:      r = 27'sd2;
            22:      r = 27'sd1;
            default: r = 27'sd0;
        endcase
        return r;
    endfunction

    // fold an angle in [0, 360] into [-90, 90] with a half-turn flag
    function automatic t_seed cordic_seed(input logic [ANG_W-1:0] a);
        t_seed s;
        s.flip = 1'b0;
        s.z    = $signed({1'b0, a});
        if (a > QUARTER_TURN && a <= THREE_QUARTER_TURN) begin
            s.z    = $signed({1'b0, a}) - $signed({1'b0, HALF_TURN});
            s.flip = 1'b1;
        end else if (a > THREE_QUARTER_TURN) begin
            s.z = $signed({1'b0, a}) - $signed({1'b0, FULL_TURN});
        end
        return s;
    endfunction

    function automatic t_vec cordic_step(input t_vec v, input int i);
        t_vec                  n;
        logic signed [Z_W-1:0] at;
        at = arctan(i);
        if (v.z >= 0) begin
            n.x = v.x - (v.y >>> i);
            n.y = v.y + (v.x >>> i);
            n.z = v.z - at;
        end else begin
            n.x = v.x + (v.y >>> i);
            n.y = v.y - (v.x >>> i);
            n.z = v.z + at;
        end
        return n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -33'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/cops_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cops_ctrl
// sequencer of the orbit step: angle advance, cordic rotations, products
// ---------------------------------------------------------------------------
module cops_ctrl
    import cops_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_xfer;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_stat.active ? S_MUL : S_OUT;
                end
            end
            S_MUL: begin
                o_cmd.step_mul = 1'b1;
                n_state        = S_ADV;
            end
            S_ADV: begin
                o_cmd.step_adv = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.cordic_load = 1'b1;
                n_state           = S_ROT;
            end
            S_ROT: begin
                o_cmd.cordic_iter = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = S_PROD1;
                end
            end
            S_PROD1: begin
                o_cmd.prod1 = 1'b1;
                n_state     = S_PROD2;
            end
            S_PROD2: begin
                o_cmd.prod2 = 1'b1;
                n_state     = S_PROD3;
            end
            S_PROD3: begin
                o_cmd.prod3 = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_rot_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT && !i_stat.iter_last) |=> (r_state == S_ROT))
        else $error("rotation left early");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_MUL || r_state == S_OUT))
        else $error("bad state after input transfer");

endmodule

// ----- hw/rtl/cops_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cops_dp
// datapath: config registers, angle accumulator, two cordic lanes, products
// ---------------------------------------------------------------------------
module cops_dp
    import cops_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  t_in_item          i_in_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output t_out_item         o_out_data
);

    logic        [23:0]       r_radius;
    logic        [24:0]       r_speed;
    logic signed [16:0]       r_tilt;
    logic                     r_has_parent;
    logic                     r_paused;
    logic        [ANG_W-1:0]  r_angle;
    logic signed [31:0]       r_held_x, r_held_y, r_held_z;

    t_in_item                 r_item;
    logic        [44:0]       r_prod_inc;
    logic        [ANG_W-1:0]  r_tilt_norm;
    t_vec                     r_lane_a, r_lane_t;
    logic                     r_flip_a, r_flip_t;
    logic        [ITER_W-1:0] r_iter;
    logic signed [56:0]       r_pc, r_ps;
    logic signed [31:0]       r_ts;
    logic signed [58:0]       r_pyp;
    t_out_item                r_out;

    logic        [28:0]       inc_raw;
    logic        [ANG_W-1:0]  inc;
    logic        [ANG_W:0]    ang_sum;
    logic        [ANG_W-1:0]  n_angle;
    logic signed [Z_W-1:0]    tilt_q;
    logic signed [Z_W-1:0]    tilt_n;
    logic signed [Z_W-1:0]    full_s;
    t_seed                    seed_a, seed_t;
    logic signed [XY_W-1:0]   cos_a, sin_a, sin_t;
    logic signed [26:0]       rs;
    logic signed [32:0]       sum_x, sum_z, sum_y;

    assign o_stat.active    = r_has_parent && !r_paused;
    assign o_stat.iter_last = (r_iter == ITER_W'(CORDIC_STAGES - 1));
    assign o_out_data       = r_out;

    // angle advance with clamp and single wrap
    assign inc_raw = r_prod_inc[44:16];
    assign inc     = (inc_raw > {3'b0, FULL_TURN}) ? FULL_TURN : inc_raw[ANG_W-1:0];
    assign ang_sum = {1'b0, r_angle} + {1'b0, inc};
    assign n_angle = (ang_sum > {1'b0, FULL_TURN}) ? ANG_W'(ang_sum - {1'b0, FULL_TURN})
                                                   : ang_sum[ANG_W-1:0];

    // tilt into [0, 360)
    assign full_s = $signed({1'b0, FULL_TURN});
    assign tilt_q = {r_tilt[16], r_tilt, 9'b0};
    always_comb begin
        tilt_n = tilt_q;
        if (tilt_q < -full_s) begin
            tilt_n = tilt_q + full_s + full_s;
        end else if (tilt_q < 0) begin
            tilt_n = tilt_q + full_s;
        end else if (tilt_q >= full_s) begin
            tilt_n = tilt_q - full_s;
        end
    end

    assign seed_a = cordic_seed(r_angle);
    assign seed_t = cordic_seed(r_tilt_norm);

    assign cos_a = r_flip_a ? -r_lane_a.x : r_lane_a.x;
    assign sin_a = r_flip_a ? -r_lane_a.y : r_lane_a.y;
    assign sin_t = r_flip_t ? -r_lane_t.y : r_lane_t.y;

    assign rs    = r_ps[56:30];
    assign sum_x = {r_item.parent_x[31], r_item.parent_x} + {{6{r_pc[56]}}, r_pc[56:30]};
    assign sum_z = {r_item.parent_z[31], r_item.parent_z} + {{6{r_ps[56]}}, r_ps[56:30]};
    assign sum_y = {r_item.parent_y[31], r_item.parent_y} + {{4{r_pyp[58]}}, r_pyp[58:30]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= '0;
            r_speed      <= '0;
            r_tilt       <= '0;
            r_has_parent <= 1'b0;
            r_paused     <= 1'b0;
            r_angle      <= '0;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_held_z     <= '0;
            r_iter       <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_RADIUS: r_radius <= i_cfg_data[23:0];
                    CFG_SPEED:  r_speed  <= i_cfg_data[24:0];
                    CFG_TILT:   r_tilt   <= i_cfg_data[16:0];
                    CFG_HAS_PARENT: begin
                        r_has_parent <= i_cfg_data[0];
                        r_angle      <= '0;
                    end
                    CFG_PAUSED: r_paused <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.step_adv) begin
                r_angle <= n_angle;
            end
            if (i_cmd.cordic_load) begin
                r_iter <= '0;
            end else if (i_cmd.cordic_iter) begin
                r_iter <= r_iter + 1'b1;
            end
            if (i_cmd.prod2) begin
                r_held_x <= sat32(sum_x);
                r_held_z <= sat32(sum_z);
            end
            if (i_cmd.prod3) begin
                r_held_y <= (r_tilt == '0) ? r_item.parent_y : sat32(sum_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.step_mul) begin
            r_prod_inc <= 45'(r_speed) * 45'(r_item.delta_time);
        end
        if (i_cmd.step_adv) begin
            r_tilt_norm <= tilt_n[ANG_W-1:0];
        end
        if (i_cmd.cordic_load) begin
            r_lane_a.x <= CORDIC_START;
            r_lane_a.y <= '0;
            r_lane_a.z <= seed_a.z;
            r_flip_a   <= seed_a.flip;
            r_lane_t.x <= CORDIC_START;
            r_lane_t.y <= '0;
            r_lane_t.z <= seed_t.z;
            r_flip_t   <= seed_t.flip;
        end else if (i_cmd.cordic_iter) begin
            r_lane_a <= cordic_step(r_lane_a, int'(r_iter));
            r_lane_t <= cordic_step(r_lane_t, int'(r_iter));
        end
        if (i_cmd.prod1) begin
            r_pc <= $signed({1'b0, r_radius}) * $signed(cos_a[31:0]);
            r_ps <= $signed({1'b0, r_radius}) * $signed(sin_a[31:0]);
            r_ts <= sin_t[31:0];
        end
        if (i_cmd.prod2) begin
            r_pyp <= rs * r_ts;
        end
        if (i_cmd.out_load) begin
            r_out.pos_x     <= r_held_x;
            r_out.pos_y     <= r_held_y;
            r_out.pos_z     <= r_held_z;
            r_out.angle_out <= r_angle;
        end
    end

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_angle <= FULL_TURN)
        else $error("kept angle beyond a full turn");

    a_iter_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cordic_load |=> (r_iter == '0))
        else $error("rotation count not restarted");

    a_out_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (o_out_data.angle_out == $past(r_angle)))
        else $error("result angle differs from kept angle");

endmodule

// ----- hw/rtl/circular_orbit_position_step.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circular_orbit_position_step
// angle accumulator driving cordic sine/cosine, orbit position around a parent
// ---------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_ready  o_out_data (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  active item: after transfer in, multiply, advance, cordic load, then the
//  CORDIC_STAGES rotation steps of the two shared-clock cordic lanes, products
//  no parent or paused: from idle straight to the result load state
//  next item accepted once the result is loaded, even if it is still waiting
//  a full result register stalls the sequencer in its last state
//  synchronous active-low reset clears config, angle and held position
// ---------------------------------------------------------------------------
module circular_orbit_position_step
    import cops_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    cops_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cops_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives the orbit position step with a short directed table and then random
// traffic under four idle and stall patterns, predicts each result in its own
// model of the angle accumulator, cordic and saturating sums, and compares
// every transfer out field by field against the oldest prediction
// ---------------------------------------------------------------------------
module testbench;
    import cops_pkg::*;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int DRAIN_CYCLES     = 30;
    localparam int RANDOM_PER_PHASE = 320;
    localparam int PRINT_LIMIT      = 40;
    localparam int SPARE_LO         = int'(CFG_PAUSED) + 1;
    localparam int SPARE_HI         = (1 << CIDX_W) - 1;

    localparam int IDLE_SEND [4] = '{0, 88, 0, 37};
    localparam int IDLE_STALL[4] = '{0, 0, 88, 37};

    localparam longint TURN    = longint'(FULL_TURN);
    localparam longint HALF    = longint'(HALF_TURN);
    localparam longint QUARTER = longint'(QUARTER_TURN);
    localparam longint GAIN    = longint'(CORDIC_START);

    localparam longint ARCTAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    localparam logic [CFG_W-1:0]  SPEED_MAX  = 25'd23592960;
    localparam logic [16:0]       TILT_HIGH  = 17'd46080;
    localparam logic [16:0]       TILT_LOW   = -17'sd46080;
    localparam logic [16:0]       TILT_RIGHT = 17'd11520;
    localparam logic signed [31:0] P_MAX     = 32'sh7FFFFFFF;
    localparam logic signed [31:0] P_MIN     = 32'sh80000000;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [CIDX_W-1:0] idx;
        logic [CFG_W-1:0]  value;
        t_in_item          item;
        bit                typed;
        t_out_item         want;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    // predictor copy of registers and state
    logic [23:0]        cfg_radius     = '0;
    logic [24:0]        cfg_speed      = '0;
    logic signed [16:0] cfg_tilt       = '0;
    bit                 cfg_has_parent = 1'b0;
    bit                 cfg_paused     = 1'b0;
    longint             pred_angle     = 0;
    logic signed [31:0] held_x         = '0;
    logic signed [31:0] held_y         = '0;
    logic signed [31:0] held_z         = '0;

    t_out_item orbit_expected[$];
    t_stim_row directed_rows[$];

    bit        row_typed = 1'b0;
    t_out_item row_want  = '0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        mismatches      = 0;
    int        items_taken     = 0;
    int        results_checked = 0;
    int        writes_taken    = 0;
    int        cycle_count     = 0;

    circular_orbit_position_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return P_MAX;
        end else if (v < -64'sd2147483648) begin
            return P_MIN;
        end
        return v[31:0];
    endfunction

    // a in [0, 360] degrees Q9.16, results Q2.30
    function automatic void orbit_trig(input longint a, output longint sn,
                                       output longint cs);
        longint z, x, y, nx;
        bit     flip;
        z    = a;
        x    = GAIN;
        y    = 0;
        flip = 1'b0;
        if (a > QUARTER && a <= 3 * QUARTER) begin
            z    = a - HALF;
            flip = 1'b1;
        end else if (a > 3 * QUARTER) begin
            z = a - TURN;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ARCTAN_DEG[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ARCTAN_DEG[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    function automatic t_out_item advance_orbit(input t_in_item it);
        longint    step, r, sn, cs, tsn, tcs, t, rs;
        t_out_item res;
        if (cfg_has_parent && !cfg_paused) begin
            step = (longint'(cfg_speed) * longint'(it.delta_time)) >>> 16;
            if (step > TURN) begin
                step = TURN;
            end
            pred_angle += step;
            if (pred_angle > TURN) begin
                pred_angle -= TURN;
            end
            orbit_trig(pred_angle, sn, cs);
            r      = longint'(cfg_radius);
            held_x = clamp32(longint'($signed(it.parent_x)) + ((r * cs) >>> 30));
            held_z = clamp32(longint'($signed(it.parent_z)) + ((r * sn) >>> 30));
            if (cfg_tilt != 0) begin
                t = longint'(cfg_tilt) * 512;
                while (t < 0) t += TURN;
                while (t >= TURN) t -= TURN;
                orbit_trig(t, tsn, tcs);
                rs     = (r * sn) >>> 30;
                held_y = clamp32(longint'($signed(it.parent_y)) + ((rs * tsn) >>> 30));
            end else begin
                held_y = it.parent_y;
            end
        end
        res.pos_x     = held_x;
        res.pos_y     = held_y;
        res.pos_z     = held_z;
        res.angle_out = ANG_W'(pred_angle);
        return res;
    endfunction

    function automatic t_stim_row write_row(input logic [CIDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] value);
        t_stim_row r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.value = value;
        r.item  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic [19:0] dt, input logic [31:0] px,
                                           input logic [31:0] py, input logic [31:0] pz);
        t_stim_row r;
        r.kind            = ROW_ITEM;
        r.idx             = '0;
        r.value           = '0;
        r.item.delta_time = dt;
        r.item.parent_x   = px;
        r.item.parent_y   = py;
        r.item.parent_z   = pz;
        r.typed           = 1'b0;
        r.want            = '0;
        return r;
    endfunction

    function automatic t_stim_row known_row(input logic [19:0] dt, input logic [31:0] px,
                                            input logic [31:0] py, input logic [31:0] pz,
                                            input t_out_item want);
        t_stim_row r;
        r       = item_row(dt, px, py, pz);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return P_MAX - 32'($urandom_range(0, 1 << 25));
            1:       return P_MIN + 32'($urandom_range(0, 1 << 25));
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        // keep the log short when the design is badly off
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch %s: got %h want %h at result %0d",
                     what, got, want, results_checked);
        end
    endtask

    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (orbit_expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, orbit_expected.size());
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && i_out_ready) begin
            if (orbit_expected.size() == 0) begin
                report_mismatch("result with no item waiting", o_out_data.pos_x, '0);
            end else begin
                want = orbit_expected.pop_front();
                if (o_out_data.pos_x !== want.pos_x)
                    report_mismatch("pos_x", o_out_data.pos_x, want.pos_x);
                if (o_out_data.pos_y !== want.pos_y)
                    report_mismatch("pos_y", o_out_data.pos_y, want.pos_y);
                if (o_out_data.pos_z !== want.pos_z)
                    report_mismatch("pos_z", o_out_data.pos_z, want.pos_z);
                if (o_out_data.angle_out !== want.angle_out)
                    report_mismatch("angle_out", 32'(o_out_data.angle_out),
                                    32'(want.angle_out));
            end
            results_checked++;
        end
        if (i_cfg_valid && o_cfg_ready) begin
            writes_taken++;
            case (i_cfg_index)
                CFG_RADIUS:     cfg_radius = i_cfg_data[23:0];
                CFG_SPEED:      cfg_speed  = i_cfg_data;
                CFG_TILT:       cfg_tilt   = i_cfg_data[16:0];
                CFG_HAS_PARENT: begin
                    cfg_has_parent = i_cfg_data[0];
                    pred_angle     = 0;
                end
                CFG_PAUSED:     cfg_paused = i_cfg_data[0];
                default: begin
                end
            endcase
        end
        if (i_in_valid && o_in_ready) begin
            want = advance_orbit(i_in_data);
            if (row_typed) begin
                want = row_want;
            end
            orbit_expected.push_back(want);
            items_taken++;
        end
    end

    initial begin
        t_in_item    it;
        logic [23:0] pick24;
        logic [24:0] pick25;
        logic [16:0] pick17;
        int          sent;
        int          seg;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        // no parent after reset: everything reads zero
        directed_rows.push_back(known_row(20'hFFFFF, P_MAX, P_MIN, 32'd0, '0));
        directed_rows.push_back(known_row(20'h00000, P_MIN, P_MAX, 32'hFFFFFFFF, '0));
        // parent set, zero radius and speed: position is the parent
        directed_rows.push_back(write_row(CFG_HAS_PARENT, 25'd1));
        directed_rows.push_back(known_row(20'hFFFFF, P_MAX, P_MAX, P_MAX,
                                          {P_MAX, P_MAX, P_MAX, 26'd0}));
        directed_rows.push_back(known_row(20'h00000, P_MIN, P_MIN, P_MIN,
                                          {P_MIN, P_MIN, P_MIN, 26'd0}));
        directed_rows.push_back(known_row(20'h12345, 32'd0, 32'hFFFFFFFF, 32'd1,
                                          {32'd0, 32'hFFFFFFFF, 32'd1, 26'd0}));
        directed_rows.push_back(write_row(CFG_TILT, {8'd0, TILT_HIGH}));
        directed_rows.push_back(known_row(20'hFFFFF, 32'h12345678, 32'hFFFFFF00, 32'd77,
                                          {32'h12345678, 32'hFFFFFF00, 32'd77, 26'd0}));
        directed_rows.push_back(write_row(CFG_TILT, {8'hFF, TILT_LOW}));
        directed_rows.push_back(known_row(20'h00001, P_MIN, P_MAX, 32'd5,
                                          {P_MIN, P_MAX, 32'd5, 26'd0}));
        // full radius and speed: whole turn, wrap, clamped step, saturation
        directed_rows.push_back(write_row(CFG_RADIUS, 25'h0FFFFFF));
        directed_rows.push_back(write_row(CFG_SPEED, SPEED_MAX));
        directed_rows.push_back(write_row(CFG_TILT, 25'd0));
        directed_rows.push_back(item_row(20'h00000, 32'd0, 32'd0, 32'd0));
        directed_rows.push_back(item_row(20'h10000, 32'd0, 32'd0, 32'd0));
        directed_rows.push_back(item_row(20'h04000, 32'd0, 32'd0, 32'd0));
        directed_rows.push_back(item_row(20'hFFFFF, 32'd100, 32'd200, 32'd300));
        directed_rows.push_back(item_row(20'h08000, P_MAX, P_MAX, P_MAX));
        directed_rows.push_back(item_row(20'h08000, P_MIN, P_MIN, P_MIN));
        directed_rows.push_back(write_row(CFG_TILT, {8'd0, TILT_RIGHT}));
        directed_rows.push_back(item_row(20'h02000, 32'd0, 32'd0, 32'd0));
        directed_rows.push_back(item_row(20'h02000, P_MAX, P_MIN, 32'hFFFFFFFB));
        directed_rows.push_back(write_row(CFG_TILT, {8'd0, TILT_LOW}));
        directed_rows.push_back(item_row(20'h03000, 32'd1000, P_MAX, 32'd0));
        // paused holds everything; spare index writes change nothing; bit 0 clear unpauses
        directed_rows.push_back(write_row(CFG_PAUSED, 25'd1));
        directed_rows.push_back(item_row(20'hFFFFF, 32'd1, 32'd2, 32'd3));
        directed_rows.push_back(write_row(CIDX_W'(SPARE_LO), 25'h1FFFFFF));
        directed_rows.push_back(write_row(CIDX_W'(SPARE_LO + 1), 25'h1FFFFFF));
        directed_rows.push_back(write_row(CIDX_W'(SPARE_HI), 25'h1FFFFFF));
        directed_rows.push_back(write_row(CFG_PAUSED, 25'h1FFFFFE));
        directed_rows.push_back(item_row(20'h05555, 32'hAAAAAAAA, 32'h55555555, 32'd9));
        // has_parent write with bit 0 clear: no parent, angle cleared
        directed_rows.push_back(write_row(CFG_HAS_PARENT, 25'h1FFFFFE));
        directed_rows.push_back(item_row(20'hAAAAA, 32'd4, 32'd5, 32'd6));
        directed_rows.push_back(write_row(CFG_HAS_PARENT, 25'd1));
        directed_rows.push_back(write_row(CFG_SPEED, 25'd1));
        directed_rows.push_back(item_row(20'h00001, 32'd7, 32'd8, 32'd9));
        directed_rows.push_back(item_row(20'hFFFFF, 32'd7, 32'd8, 32'd9));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_WRITE) begin
                drain_results();
                write_reg(directed_rows[n].idx, directed_rows[n].value);
            end else begin
                row_typed = directed_rows[n].typed;
                row_want  = directed_rows[n].want;
                send_item(directed_rows[n].item);
            end
        end
        row_typed = 1'b0;

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = IDLE_SEND[phase];
            stall_pct     = IDLE_STALL[phase];
            sent          = 0;
            while (sent < RANDOM_PER_PHASE) begin
                drain_results();
                if ($urandom_range(0, 9) < 6) begin
                    case ($urandom_range(0, 3))
                        0:       pick24 = '0;
                        1:       pick24 = '1;
                        default: pick24 = 24'($urandom);
                    endcase
                    write_reg(CFG_RADIUS, {1'($urandom_range(0, 1)), pick24});
                end
                if ($urandom_range(0, 9) < 6) begin
                    case ($urandom_range(0, 4))
                        0:       pick25 = '0;
                        1:       pick25 = SPEED_MAX;
                        2:       pick25 = 25'($urandom_range(0, 1 << 18));
                        default: pick25 = 25'($urandom_range(0, 23592960));
                    endcase
                    write_reg(CFG_SPEED, pick25);
                end
                if ($urandom_range(0, 9) < 6) begin
                    case ($urandom_range(0, 4))
                        0:       pick17 = '0;
                        1:       pick17 = TILT_HIGH;
                        2:       pick17 = TILT_LOW;
                        default: pick17 = 17'($urandom_range(0, 92160) - 46080);
                    endcase
                    write_reg(CFG_TILT, {8'($urandom), pick17});
                end
                if ($urandom_range(0, 9) < 3) begin
                    write_reg(CFG_HAS_PARENT,
                              {24'($urandom), 1'($urandom_range(0, 9) != 0)});
                end
                if ($urandom_range(0, 9) < 4) begin
                    write_reg(CFG_PAUSED, {24'($urandom), 1'($urandom_range(0, 5) == 0)});
                end
                if ($urandom_range(0, 19) == 0) begin
                    write_reg(CIDX_W'($urandom_range(SPARE_LO, SPARE_HI)), 25'($urandom));
                end
                seg = $urandom_range(1, 60);
                if (seg > RANDOM_PER_PHASE - sent) begin
                    seg = RANDOM_PER_PHASE - sent;
                end
                repeat (seg) begin
                    case ($urandom_range(0, 3))
                        0:       it.delta_time = 20'($urandom_range(0, 4095));
                        1:       it.delta_time = 20'($urandom_range(0, 131071));
                        default: it.delta_time = 20'($urandom);
                    endcase
                    it.parent_x = random_coord();
                    it.parent_y = random_coord();
                    it.parent_z = random_coord();
                    send_item(it);
                    sent++;
                end
            end
        end

        drain_results();
        $display("summary: %0d items in, %0d results compared, %0d register writes",
                 items_taken, results_checked, writes_taken);
        $display("summary: directed extremes, then random traffic under four idle patterns");
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cops_pkg.sv
hw/rtl/cops_ctrl.sv
hw/rtl/cops_dp.sv
hw/rtl/circular_orbit_position_step.sv
bench/testbench.sv
